/* hw/rtl/alir_pkg.sv */
// Shared types and constants for the array list insert/remove unit.
package alir_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ENTRY_WIDTH = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 3;
    localparam int POS_W       = 11;
    localparam int DATA_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ENTRY_WIDTH-1:0] entry_t;
    typedef logic [QPTR_W-1:0]      qptr_t;
    typedef logic [QFILL_W-1:0]     qfill_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_REM_AT    = 3'd5,
        CMD_READ_AT   = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MOVE,
        BK_WRITE,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] entry_data;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] removed_data;
        logic [POS_W-1:0]  entry_count;
    } out_t;

    // A classified command as handed from the front end to the back end.
    typedef struct packed {
        op_t     op;
        status_t status;
        addr_t   at;
        addr_t   start;
        cnt_t    moves;
        cnt_t    new_count;
        entry_t  data;
    } qitem_t;

endpackage

/* hw/rtl/alir_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module alir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/alir_front.sv */
// Front end: accepts commands, checks them against the tracked count and classifies them.
module alir_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  alir_pkg::in_t     s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output alir_pkg::qitem_t  push_item
);

    alir_pkg::cnt_t   count_reg;
    alir_pkg::cnt_t   count_next;
    alir_pkg::cnt_t   at_w;
    alir_pkg::qitem_t item;
    logic             is_ins;
    logic             is_rem;
    logic             is_read;

    always_comb begin
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        is_read = 1'b0;
        at_w    = alir_pkg::cnt_t'(s_data.position);
        case (s_data.cmd)
            alir_pkg::CMD_INS_FRONT: begin
                is_ins = 1'b1;
                at_w   = '0;
            end
            alir_pkg::CMD_INS_BACK: begin
                is_ins = 1'b1;
                at_w   = count_reg;
            end
            alir_pkg::CMD_INS_AT: begin
                is_ins = 1'b1;
            end
            alir_pkg::CMD_REM_FRONT: begin
                is_rem = 1'b1;
                at_w   = '0;
            end
            alir_pkg::CMD_REM_BACK: begin
                is_rem = 1'b1;
                at_w   = count_reg - alir_pkg::cnt_t'(1);
            end
            alir_pkg::CMD_REM_AT: begin
                is_rem = 1'b1;
            end
            alir_pkg::CMD_READ_AT: begin
                is_read = 1'b1;
            end
            default: begin
                at_w = '0;
            end
        endcase

        item.op        = alir_pkg::OP_NONE;
        item.status    = alir_pkg::ST_OK;
        item.at        = at_w[alir_pkg::ADDR_W-1:0];
        item.start     = at_w[alir_pkg::ADDR_W-1:0];
        item.moves     = '0;
        item.new_count = count_reg;
        item.data      = s_data.entry_data[alir_pkg::ENTRY_WIDTH-1:0];

        if (is_ins) begin
            if (count_reg == alir_pkg::cnt_t'(alir_pkg::CAPACITY)) begin
                item.status = alir_pkg::ST_FULL;
            end else if (at_w > count_reg) begin
                item.status = alir_pkg::ST_RANGE;
            end else begin
                // Entries from the top down to the gap move up one place.
                item.op        = alir_pkg::OP_INSERT;
                item.start     = alir_pkg::addr_t'(count_reg - alir_pkg::cnt_t'(1));
                item.moves     = count_reg - at_w;
                item.new_count = count_reg + alir_pkg::cnt_t'(1);
            end
        end else if (is_rem || is_read) begin
            if (count_reg == '0) begin
                item.status = alir_pkg::ST_EMPTY;
            end else if (at_w >= count_reg) begin
                item.status = alir_pkg::ST_RANGE;
            end else if (is_read) begin
                item.op    = alir_pkg::OP_READ;
                item.moves = alir_pkg::cnt_t'(1);
            end else begin
                item.op        = alir_pkg::OP_REMOVE;
                item.moves     = count_reg - at_w;
                item.new_count = count_reg - alir_pkg::cnt_t'(1);
            end
        end

        count_next = count_reg;
        if (s_valid && push_ready) begin
            count_next = item.new_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign push_item  = item;

endmodule

/* hw/rtl/alir_queue.sv */
// Short queue of classified commands between the front end and the back end.
module alir_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  alir_pkg::qitem_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output alir_pkg::qitem_t pop_item
);

    alir_pkg::qitem_t slot_reg [alir_pkg::QUEUE_DEPTH];
    alir_pkg::qptr_t  wr_ptr_reg;
    alir_pkg::qptr_t  wr_ptr_next;
    alir_pkg::qptr_t  rd_ptr_reg;
    alir_pkg::qptr_t  rd_ptr_next;
    alir_pkg::qfill_t fill_reg;
    alir_pkg::qfill_t fill_next;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        push_ready  = (fill_reg != alir_pkg::qfill_t'(alir_pkg::QUEUE_DEPTH));
        pop_valid   = (fill_reg != '0);
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + alir_pkg::qptr_t'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + alir_pkg::qptr_t'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + alir_pkg::qfill_t'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - alir_pkg::qfill_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    assign pop_item = slot_reg[rd_ptr_reg];

endmodule

/* hw/rtl/alir_back.sv */
// Back end: carries out shifts, reads and writes on the list memory and drives results.
module alir_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  alir_pkg::qitem_t pop_item,
    output logic             m_valid,
    input  logic             m_ready,
    output alir_pkg::out_t   m_data
);

    alir_pkg::back_state_t state_reg;
    alir_pkg::back_state_t state_next;
    alir_pkg::qitem_t      item_reg;
    alir_pkg::qitem_t      item_next;
    alir_pkg::addr_t       rp_reg;
    alir_pkg::addr_t       rp_next;
    alir_pkg::cnt_t        left_reg;
    alir_pkg::cnt_t        left_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    alir_pkg::addr_t       pend_addr_reg;
    alir_pkg::addr_t       pend_addr_next;
    logic                  pend_capture_reg;
    logic                  pend_capture_next;
    alir_pkg::entry_t      taken_reg;
    alir_pkg::entry_t      taken_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    alir_pkg::out_t        m_data_reg;
    alir_pkg::out_t        m_data_next;

    logic                  ram_we;
    alir_pkg::addr_t       ram_waddr;
    alir_pkg::entry_t      ram_wdata;
    logic                  ram_re;
    alir_pkg::addr_t       ram_raddr;
    alir_pkg::entry_t      ram_rdata;
    logic                  is_insert;

    alir_ram #(
        .WIDTH (alir_pkg::ENTRY_WIDTH),
        .DEPTH (alir_pkg::CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        rp_next           = rp_reg;
        left_next         = left_reg;
        pend_valid_next   = pend_valid_reg;
        pend_addr_next    = pend_addr_reg;
        pend_capture_next = pend_capture_reg;
        taken_next        = taken_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        pop_ready         = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = item_reg.at;
        ram_wdata         = item_reg.data;
        ram_re            = 1'b0;
        ram_raddr         = rp_reg;
        is_insert         = (item_reg.op == alir_pkg::OP_INSERT);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            alir_pkg::BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    item_next       = pop_item;
                    rp_next         = pop_item.start;
                    left_next       = pop_item.moves;
                    pend_valid_next = 1'b0;
                    taken_next      = '0;
                    if (pop_item.op == alir_pkg::OP_NONE) begin
                        state_next = alir_pkg::BK_RESULT;
                    end else begin
                        state_next = alir_pkg::BK_MOVE;
                    end
                end
            end
            alir_pkg::BK_MOVE: begin
                // Retire the read issued last cycle: keep it or move it one place.
                if (pend_valid_reg) begin
                    if (pend_capture_reg) begin
                        taken_next = ram_rdata;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_addr_reg;
                        ram_wdata = ram_rdata;
                    end
                end
                if (left_reg != '0) begin
                    ram_re            = 1'b1;
                    pend_valid_next   = 1'b1;
                    pend_capture_next = (item_reg.op == alir_pkg::OP_READ) ||
                                        ((item_reg.op == alir_pkg::OP_REMOVE) &&
                                         (rp_reg == item_reg.at));
                    left_next         = left_reg - alir_pkg::cnt_t'(1);
                    if (is_insert) begin
                        pend_addr_next = rp_reg + alir_pkg::addr_t'(1);
                        rp_next        = rp_reg - alir_pkg::addr_t'(1);
                    end else begin
                        pend_addr_next = rp_reg - alir_pkg::addr_t'(1);
                        rp_next        = rp_reg + alir_pkg::addr_t'(1);
                    end
                end else begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg) begin
                        if (is_insert) begin
                            state_next = alir_pkg::BK_WRITE;
                        end else begin
                            state_next = alir_pkg::BK_RESULT;
                        end
                    end
                end
            end
            alir_pkg::BK_WRITE: begin
                ram_we     = 1'b1;
                state_next = alir_pkg::BK_RESULT;
            end
            alir_pkg::BK_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = item_reg.status;
                    m_data_next.removed_data = alir_pkg::DATA_W'(taken_reg);
                    m_data_next.entry_count  = alir_pkg::POS_W'(item_reg.new_count);
                    state_next               = alir_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = alir_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        rp_reg           <= rp_next;
        left_reg         <= left_next;
        pend_addr_reg    <= pend_addr_next;
        pend_capture_reg <= pend_capture_next;
        taken_reg        <= taken_next;
        m_data_reg       <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= alir_pkg::BK_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hw/rtl/array_list_insert_remove_unit.sv */
// Top level of the array list insert/remove unit.
//
// The block keeps an ordered list of up to 1024 entry words in one memory.
// Commands arrive on the s_ channel (valid/ready); each transaction carries a
// command code, a position and an entry word. Every command yields exactly
// one result transaction on the m_ channel with a status, the removed or
// read word (zero otherwise) and the entry count after the command.
//
// The front end checks each command against its own copy of the count, so
// full, empty and out-of-range commands are flagged without touching memory.
// A two-entry queue lets the front end take new commands while the back end
// moves one entry per cycle through the memory's single write port. From the
// back end taking a command to its result, an insert passes through the move,
// write and result states, a remove or a read through the move and result
// states, and a rejected command goes straight to the result state.
//
// A stalled m_ready holds the finished result in the output register; the back
// end then stops before its next result and the queue fills, after which
// s_ready drops. A synchronous low aresetn empties the list (count zero);
// the memory contents are not cleared, since only written entries are read.
module array_list_insert_remove_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  alir_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output alir_pkg::out_t m_data
);

    // Classified commands on their way from the front end to the queue.
    logic             push_valid;
    logic             push_ready;
    alir_pkg::qitem_t push_item;

    // Classified commands on their way from the queue to the back end.
    logic             pop_valid;
    logic             pop_ready;
    alir_pkg::qitem_t pop_item;

    alir_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    alir_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    alir_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
